// ----- hw/rtl/lru_key_value_cache_assert.svh -----
// Assertion macros for the LRU key-value cache.
// No dependencies; included by files that check their own logic.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define LKV_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset
`define LKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LKV_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define LKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/lkv_pkg.sv -----
// Shared constants, types and width helpers for the LRU key-value cache.
// No dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 32;

    localparam int FIELD_W = 32;    // key/value width on the ports
    localparam int CAP_W   = 5;     // capacity register width

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Broadcast from the control to every cell during the work cycle
    typedef struct packed {
        logic apply;     // commit updates at this edge
        logic is_put;
        logic hit_any;   // some cell matched the key
        logic insert;    // put miss, room left: fill slot used_count
        logic evict;     // put miss, full: replace least recent
    } lkv_ctrl_t;

    function automatic int rank_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int count_bits(input int n);
        return $clog2(n + 1);
    endfunction

endpackage

// ----- hw/rtl/lkv_req_if.sv -----
// Request channel (valid/ready) for the LRU key-value cache.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

interface lkv_req_if;
    import lkv_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [FIELD_W-1:0] lookup_key;
    logic [FIELD_W-1:0] write_value;

    modport source (output valid, output opcode, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input opcode, input lookup_key, input write_value,
                    output ready);
endinterface

// ----- hw/rtl/lkv_rsp_if.sv -----
// Response channel (valid/ready) for the LRU key-value cache.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

interface lkv_rsp_if;
    import lkv_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIELD_W-1:0] read_value;
    logic               evicted;
    logic [FIELD_W-1:0] evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

// ----- hw/rtl/lkv_cell.sv -----
// One slot of the cache: key, value and recency rank, plus chain logic.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_cell #(
    parameter int IDX         = 0,
    parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = lkv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = lkv_pkg::DEF_VALUE_BITS
) (
    input  logic                                              clk,
    input  lkv_pkg::lkv_ctrl_t                                ctrl,
    input  logic [KEY_BITS-1:0]                               req_key,
    input  logic [VALUE_BITS-1:0]                             req_value,
    input  logic [lkv_pkg::count_bits(MAX_ENTRIES)-1:0]       used_count,
    input  logic [lkv_pkg::count_bits(MAX_ENTRIES)-1:0]       target_rank,
    input  logic                                              seen_in,
    output logic                                              seen_out,
    input  logic [lkv_pkg::rank_bits(MAX_ENTRIES)-1:0]        rank_in,
    output logic [lkv_pkg::rank_bits(MAX_ENTRIES)-1:0]        rank_out,
    input  logic [KEY_BITS-1:0]                               key_in,
    output logic [KEY_BITS-1:0]                               key_out,
    input  logic [VALUE_BITS-1:0]                             value_in,
    output logic [VALUE_BITS-1:0]                             value_out
);
    import lkv_pkg::*;

    localparam int CW = count_bits(MAX_ENTRIES);
    localparam int RW = rank_bits(MAX_ENTRIES);
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [RW-1:0]         rank_reg;
    logic [CW-1:0]         rank_ext;

    logic valid;
    logic match;
    logic first;
    logic sel;

    assign rank_ext = CW'(rank_reg);
    assign valid    = MY_IDX < used_count;
    assign match    = valid && (key_reg == req_key);
    assign first    = match && !seen_in;
    assign seen_out = seen_in || match;
    assign rank_out = rank_in | (first ? rank_reg : '0);

    // Slot chosen for this access: lowest hit, next free slot, or the least recent
    assign sel = (ctrl.hit_any && first)
              || (ctrl.insert && (MY_IDX == used_count))
              || (ctrl.evict && valid && (rank_ext == used_count - CW'(1)));

    assign key_out   = key_in   | (sel ? key_reg   : '0);
    assign value_out = value_in | (sel ? value_reg : '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.apply)
        begin
            if (sel)
                rank_reg <= '0;
            else if (valid && (rank_ext < target_rank))
                rank_reg <= rank_reg + RW'(1);
            if (sel && ctrl.is_put)
            begin
                key_reg   <= req_key;
                value_reg <= req_value;
            end
        end
    end

endmodule

// ----- hw/rtl/lru_key_value_cache.sv -----
// LRU key-value cache: a row of MAX_ENTRIES cells searched in parallel.
// A request is captured, compared and updated across the cell row in the work cycle,
// and its result is registered. No new request is taken during the work cycle, nor
// while a result waits that the sink does not take. Reset: entry count cleared,
// capacity register set to 16; slot storage is not cleared, slots at or above
// the entry count are ignored. Depends on lkv_pkg, lkv_req_if, lkv_rsp_if, lkv_cell.
`timescale 1ns / 1ps
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = lkv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = lkv_pkg::DEF_VALUE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [lkv_pkg::CAP_W-1:0]   cfg_write_data,
    lkv_req_if.sink                     req,
    lkv_rsp_if.source                   rsp
);
    import lkv_pkg::*;

    localparam int CW   = count_bits(MAX_ENTRIES);
    localparam int RW   = rank_bits(MAX_ENTRIES);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [CMPW-1:0] MAX_CMP = CMPW'(MAX_ENTRIES);

    // ------------------------------------------------------------------
    // Control and request registers
    // ------------------------------------------------------------------
    logic [CAP_W-1:0]      capacity_reg;
    logic [CW-1:0]         entries_used_reg, entries_used_next;
    logic                  busy_reg;          // work cycle in progress
    logic                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    // Output register: holds a finished result until the sink takes it
    logic                  rsp_valid_reg;
    logic                  hit_reg;
    logic [FIELD_W-1:0]    read_value_reg;
    logic                  evicted_reg;
    logic [FIELD_W-1:0]    evicted_key_reg;

    logic req_xfer;
    logic rsp_xfer;

    // Room check against the clamped capacity (0 acts as 1, above max acts as max)
    logic [CMPW-1:0] cap_cmp;
    logic [CMPW-1:0] eff_cap;
    logic            room;

    // Cell row chains: index i feeds cell i, index MAX_ENTRIES is the row output
    logic                  seen_chain  [MAX_ENTRIES+1];
    logic [RW-1:0]         rank_chain  [MAX_ENTRIES+1];
    logic [KEY_BITS-1:0]   key_chain   [MAX_ENTRIES+1];
    logic [VALUE_BITS-1:0] value_chain [MAX_ENTRIES+1];

    lkv_ctrl_t     ctrl;
    logic [CW-1:0] target_rank;
    logic          is_put;

    assign req.ready = !busy_reg && (!rsp_valid_reg || rsp.ready);
    assign req_xfer  = req.valid && req.ready;
    assign rsp_xfer  = rsp_valid_reg && rsp.ready;

    assign cap_cmp = CMPW'(capacity_reg);
    assign eff_cap = (cap_cmp == '0) ? CMPW'(1) : ((cap_cmp > MAX_CMP) ? MAX_CMP : cap_cmp);
    assign room    = CMPW'(entries_used_reg) < eff_cap;

    // ------------------------------------------------------------------
    // Decision for the work cycle, broadcast to all cells
    // ------------------------------------------------------------------
    assign is_put = (op_reg == OP_PUT);

    always_comb
    begin
        ctrl.apply   = busy_reg;
        ctrl.is_put  = is_put;
        ctrl.hit_any = seen_chain[MAX_ENTRIES];
        ctrl.insert  = !seen_chain[MAX_ENTRIES] && is_put && room;
        ctrl.evict   = !seen_chain[MAX_ENTRIES] && is_put && !room
                       && (entries_used_reg != '0);
    end

    // Entries younger than the target age by one. Insert: every entry ages.
    // Evict: the target is the least recent entry itself. Get miss: nothing ages.
    always_comb
    begin
        if (ctrl.hit_any)
            target_rank = CW'(rank_chain[MAX_ENTRIES]);
        else if (ctrl.insert)
            target_rank = entries_used_reg;
        else if (ctrl.evict)
            target_rank = entries_used_reg - CW'(1);
        else
            target_rank = '0;
    end

    assign entries_used_next = (busy_reg && ctrl.insert) ? entries_used_reg + CW'(1)
                                                         : entries_used_reg;

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    assign seen_chain[0]  = 1'b0;
    assign rank_chain[0]  = '0;
    assign key_chain[0]   = '0;
    assign value_chain[0] = '0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        lkv_cell #(
            .IDX         (i),
            .MAX_ENTRIES (MAX_ENTRIES),
            .KEY_BITS    (KEY_BITS),
            .VALUE_BITS  (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .req_key     (key_reg),
            .req_value   (value_reg),
            .used_count  (entries_used_reg),
            .target_rank (target_rank),
            .seen_in     (seen_chain[i]),
            .seen_out    (seen_chain[i+1]),
            .rank_in     (rank_chain[i]),
            .rank_out    (rank_chain[i+1]),
            .key_in      (key_chain[i]),
            .key_out     (key_chain[i+1]),
            .value_in    (value_chain[i]),
            .value_out   (value_chain[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= CAP_RESET;
            entries_used_reg <= '0;
            busy_reg         <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                capacity_reg <= cfg_write_data;
            entries_used_reg <= entries_used_next;
            if (req_xfer)
                busy_reg <= 1'b1;
            else if (busy_reg)
                busy_reg <= 1'b0;
            if (busy_reg)
                rsp_valid_reg <= 1'b1;
            else if (rsp_xfer)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload: request capture and result capture
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg    <= req.opcode;
            key_reg   <= KEY_BITS'(req.lookup_key);
            value_reg <= VALUE_BITS'(req.write_value);
        end
        if (busy_reg)
        begin
            hit_reg         <= ctrl.hit_any;
            read_value_reg  <= (ctrl.hit_any && !is_put)
                               ? FIELD_W'(value_chain[MAX_ENTRIES]) : '0;
            evicted_reg     <= ctrl.evict;
            evicted_key_reg <= ctrl.evict ? FIELD_W'(key_chain[MAX_ENTRIES]) : '0;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.evicted     = evicted_reg;
    assign rsp.evicted_key = evicted_key_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LKV_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, CMPW'(entries_used_reg) <= MAX_CMP, "entry count above maximum")
    `LKV_ASSERT_NEXT(a_xfer_busy, clk, rst_n, req_xfer, busy_reg && !req.ready, "no work cycle after request transfer")
    `LKV_ASSERT_NEXT(a_hit_keeps_count, clk, rst_n, busy_reg && ctrl.hit_any, $stable(entries_used_reg), "entry count changed on a hit")
    `LKV_ASSERT_NEXT(a_insert_grows, clk, rst_n, busy_reg && ctrl.insert, entries_used_reg == $past(entries_used_reg) + CW'(1), "insert did not grow entry count")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking bench for lru_key_value_cache: gets and puts over a range of capacities.
// Depends on lkv_pkg, lkv_req_if, lkv_rsp_if and the cache RTL.
`timescale 1ns / 1ps

module testbench;
    import lkv_pkg::*;

    // One response transfer as the cache should produce it
    typedef struct {
        logic               hit;
        logic [FIELD_W-1:0] read_value;
        logic               evicted;
        logic [FIELD_W-1:0] evicted_key;
    } cache_result_t;

    localparam int SLOTS = DEF_MAX_ENTRIES;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic [CAP_W-1:0] cfg_write_data;

    lkv_req_if req_bus();
    lkv_rsp_if rsp_bus();

    lru_key_value_cache DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req_bus),
        .rsp            (rsp_bus)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the cache: keys, values and recency age per slot.
    // Age 0 is most recent, slots_filled-1 is least recent.
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] slot_key   [SLOTS];
    logic [FIELD_W-1:0] slot_value [SLOTS];
    int unsigned        slot_age   [SLOTS];
    int unsigned        slots_filled     = 0;
    logic [CAP_W-1:0]   capacity_setting = CAP_RESET;

    cache_result_t expected_results[$];

    // Run bookkeeping
    bit idling_on        = 1'b1;
    int rx_hold_cycles   = 0;     // long output stall requested by a test
    int rx_stall_left    = 0;     // remaining cycles of a random stall burst
    int mismatch_count   = 0;
    int requests_sent    = 0;
    int results_seen     = 0;
    int hits_seen        = 0;
    int evictions_seen   = 0;
    int settings_used    = 0;

    // Register value 0 behaves as 1, anything above the slot count as the slot count
    function automatic int unsigned effective_capacity();
        int unsigned c;
        c = capacity_setting;
        if (c < 1)
            c = 1;
        if (c > SLOTS)
            c = SLOTS;
        return c;
    endfunction

    // Slot s becomes most recent; everything that was more recent ages by one
    function automatic void promote_slot(input int unsigned s);
        int unsigned old_age;
        old_age = slot_age[s];
        for (int unsigned j = 0; j < slots_filled; j++)
        begin
            if (slot_age[j] < old_age)
                slot_age[j]++;
        end
        slot_age[s] = 0;
    endfunction

    // Applies one request to the shadow cache and returns the response it should give
    function automatic cache_result_t predict_access(input logic op,
                                                     input logic [FIELD_W-1:0] key,
                                                     input logic [FIELD_W-1:0] value);
        cache_result_t r;
        bit            found;
        int unsigned   slot;
        r       = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
        found   = 1'b0;
        slot    = 0;
        // lowest matching slot wins (keys are unique anyway)
        for (int unsigned i = 0; i < slots_filled; i++)
        begin
            if (!found && slot_key[i] == key)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            if (op == OP_PUT)
                slot_value[slot] = value;
            else
                r.read_value = slot_value[slot];
            promote_slot(slot);
        end
        else if (op == OP_PUT)
        begin
            if (slots_filled < effective_capacity())
            begin
                // room left: new pair goes to the next free slot as most recent
                for (int unsigned i = 0; i < slots_filled; i++)
                    slot_age[i]++;
                slot_key[slots_filled]   = key;
                slot_value[slots_filled] = value;
                slot_age[slots_filled]   = 0;
                slots_filled++;
            end
            else
            begin
                // full, or capacity lowered below the fill level: replace the oldest
                for (int unsigned i = 0; i < slots_filled; i++)
                begin
                    if (slot_age[i] == slots_filled - 1)
                        slot = i;
                end
                r.evicted        = 1'b1;
                r.evicted_key    = slot_key[slot];
                slot_key[slot]   = key;
                slot_value[slot] = value;
                promote_slot(slot);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting; output is capped so a dead block does not flood the log
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("tb: MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Compares one response transfer with the oldest expectation
    task automatic check_response();
        cache_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("response with nothing outstanding (hit=%0b evicted=%0b)",
                                      rsp_bus.hit, rsp_bus.evicted));
            return;
        end
        want = expected_results.pop_front();
        if (rsp_bus.hit !== want.hit)
            report_mismatch($sformatf("response %0d: hit %0b, expected %0b",
                                      results_seen, rsp_bus.hit, want.hit));
        if (rsp_bus.read_value !== want.read_value)
            report_mismatch($sformatf("response %0d: read_value %h, expected %h",
                                      results_seen, rsp_bus.read_value, want.read_value));
        if (rsp_bus.evicted !== want.evicted)
            report_mismatch($sformatf("response %0d: evicted %0b, expected %0b",
                                      results_seen, rsp_bus.evicted, want.evicted));
        if (rsp_bus.evicted_key !== want.evicted_key)
            report_mismatch($sformatf("response %0d: evicted_key %h, expected %h",
                                      results_seen, rsp_bus.evicted_key, want.evicted_key));
        if (want.hit)
            hits_seen++;
        if (want.evicted)
            evictions_seen++;
        results_seen++;
    endtask

    // Response monitor: values read here are the ones present before the edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            check_response();
    end

    // Response side ready: random stall bursts, or a long hold when a test asks for one.
    // The hold is counted down here, at every edge.
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp_bus.ready <= 1'b0;
            else if (rx_hold_cycles > 0)
            begin
                rsp_bus.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                rx_stall_left--;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                rx_stall_left = $urandom_range(0, 10);
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request and returns at the edge of its transfer. valid stays high
    // so a following call can go back to back; end_burst() drops it.
    task automatic send_request(input logic op, input logic [FIELD_W-1:0] key,
                                input logic [FIELD_W-1:0] value);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 11);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.opcode      <= op;
        req_bus.lookup_key  <= key;
        req_bus.write_value <= value;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        expected_results.push_back(predict_access(op, key, value));
        requests_sent++;
    endtask

    task automatic end_burst();
        req_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Blocks until every outstanding response has been transferred
    task automatic wait_for_results();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write only while idle: drain, let the pipe settle, then write
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_for_results();
        repeat (4) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= cap;
        @(posedge clk);
        cfg_write_en     <= 1'b0;
        capacity_setting = cap;
        settings_used++;
    endtask

    // Random traffic over a key pool a little larger than the capacity, so hits,
    // inserts and evictions all stay frequent. A few keys come from outside the pool.
    task automatic run_random_phase(input int count);
        logic [FIELD_W-1:0] key_pool[$];
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
        logic               op;
        int                 pool_size;
        pool_size = effective_capacity() + $urandom_range(1, 6);
        for (int i = 0; i < pool_size; i++)
        begin
            case ($urandom_range(0, 15))
                0:       key = '0;
                1:       key = '1;
                default: key = $urandom;
            endcase
            key_pool.push_back(key);
        end
        for (int n = 0; n < count; n++)
        begin
            op = ($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET;
            if ($urandom_range(0, 9) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            case ($urandom_range(0, 19))
                0:       value = '0;
                1:       value = '1;
                default: value = $urandom;
            endcase
            send_request(op, key, value);
        end
        end_burst();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, both operations, capacity 0 / lowered / above the slot count
    task automatic test_directed();
        // empty cache: a get can only miss
        send_request(OP_GET, 32'h1234_5678, $urandom);
        send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // all-ones value is an ordinary value
        send_request(OP_GET, 32'hFFFF_FFFF, $urandom);
        send_request(OP_GET, 32'h0000_0000, $urandom);
        // put hit overwrites
        send_request(OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
        send_request(OP_GET, 32'h0000_0000, $urandom);
        send_request(OP_GET, 32'h0000_0001, $urandom);
        end_burst();

        // capacity exactly at the fill level: put misses now evict
        set_capacity(5'd2);
        send_request(OP_PUT, 32'h0000_0005, 32'h5A5A_5A5A);
        send_request(OP_GET, 32'hFFFF_FFFF, $urandom);
        send_request(OP_PUT, 32'h0000_0006, 32'h0000_0001);
        end_burst();

        // zero behaves as one; fill level stays above it and keeps evicting
        set_capacity(5'd0);
        send_request(OP_PUT, 32'h0000_0007, 32'h8000_0000);
        send_request(OP_GET, 32'h0000_0006, $urandom);
        send_request(OP_PUT, 32'h0000_0008, 32'h7FFF_FFFF);
        send_request(OP_PUT, 32'h0000_0008, 32'hFFFF_FFFE);
        end_burst();

        // above the slot count: clamps to all slots
        set_capacity(5'd31);
        for (int i = 0; i < 6; i++)
            send_request(OP_PUT, 32'h8000_0000 | i, $urandom);
        send_request(OP_GET, 32'h0000_0006, $urandom);
        end_burst();
    endtask

    task automatic test_capacity_sweep();
        int caps[9] = '{16, 1, 5, 0, 31, 2, 12, 17, 16};
        foreach (caps[i])
        begin
            set_capacity(CAP_W'(caps[i]));
            run_random_phase(140);
        end
    endtask

    // Output held off for a long stretch while requests keep coming: the block
    // must fill up and drop ready on the request side
    task automatic test_output_backpressure();
        set_capacity(5'd4);
        idling_on      = 1'b0;
        rx_hold_cycles = 200;
        @(posedge clk);
        run_random_phase(40);
        idling_on = 1'b1;
    endtask

    // Sender stops until the pipe is empty, then resumes with the same contents
    task automatic test_sender_pause();
        run_random_phase(20);
        wait_for_results();
        repeat ($urandom_range(1, 11)) @(posedge clk);
        run_random_phase(20);
    endtask

    // Last stretch: no idling on either side
    task automatic test_back_to_back();
        set_capacity(CAP_W'($urandom_range(0, 31)));
        idling_on = 1'b0;
        run_random_phase(220);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               <= 1'b0;
        cfg_write_en        <= 1'b0;
        cfg_write_data      <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.opcode      <= OP_GET;
        req_bus.lookup_key  <= '0;
        req_bus.write_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_capacity_sweep();
        test_output_backpressure();
        test_sender_pause();
        test_back_to_back();

        // drain, then give any stray response time to show up
        wait_for_results();
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_results.size()));

        $display("tb: %0d requests, %0d responses checked, %0d hits, %0d evictions",
                 requests_sent, results_seen, hits_seen, evictions_seen);
        $display("tb: %0d capacity writes incl. 0, 1, 16, 17, 31; long output stall; sender pause",
                 settings_used);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: a correct run finishes well inside this limit even with every stall
    // at its longest.
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
